@@ rtl/ecint_pkg.sv @@
package ecint_pkg;

  // Curve selector codes carried on the action field
  typedef enum logic [3:0] {
    CURVE_QUAD_IN         = 4'd0,
    CURVE_QUAD_OUT        = 4'd1,
    CURVE_QUAD_INOUT      = 4'd2,
    CURVE_BACK_IN         = 4'd3,
    CURVE_BACK_OUT        = 4'd4,
    CURVE_BACK_INOUT      = 4'd5,
    CURVE_BOUNCE_OUT      = 4'd6,
    CURVE_BOUNCE_IN       = 4'd7,
    CURVE_BOUNCE_INOUT    = 4'd8
  } curve_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned TicksW = 16;

  // Side band that travels with every request through the pipeline
  typedef struct packed {
    logic [3:0]        sel;
    logic [ValueW-1:0] start_val;
    logic [ValueW-1:0] end_val;
    logic              bad;
  } item_t;

endpackage

@@ rtl/ecint_div.sv @@
module ecint_div import ecint_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  item_t                item_i,
  input  logic [TicksW-1:0]    elapsed_i,
  input  logic [TicksW-1:0]    duration_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output item_t                item_o,
  output logic [FRAC_BITS:0]   u_o
);

  localparam int unsigned TW = (TIME_BITS < TicksW) ? TIME_BITS : TicksW;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NS = FRAC_BITS + 2;

  logic [NS-1:0]   v_w;
  logic [NS-1:0]   rdy;
  item_t           it_w [NS];
  logic [TW-1:0]   r_w  [NS];
  logic [TW-1:0]   d_w  [NS];
  logic [QW-1:0]   q_w  [NS];

  // Ready chain: a stage loads when empty or when the next stage moves
  assign rdy[NS-1] = !v_w[NS-1] || !out_stall_i;
  for (genvar g = 0; g < NS - 1; g++) begin : g_rdy
    assign rdy[g] = !v_w[g] || rdy[g+1];
  end

  // Input stage: clamp elapsed time, flag zero duration
  logic          v0_q;
  item_t         it0_q;
  item_t         it_in;
  logic [TW-1:0] r0_q, d0_q;
  logic [TW-1:0] t_in, d_in;

  assign t_in = elapsed_i[TW-1:0];
  assign d_in = duration_i[TW-1:0];

  always_comb begin
    it_in     = item_i;
    it_in.bad = (d_in == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      it0_q     <= it_in;
      r0_q      <= (t_in > d_in) ? d_in : t_in;
      d0_q      <= d_in;
    end
  end

  assign v_w[0]  = v0_q;
  assign it_w[0] = it0_q;
  assign r_w[0]  = r0_q;
  assign d_w[0]  = d0_q;
  assign q_w[0]  = '0;

  // Restoring division, one quotient bit per stage
  for (genvar i = 1; i < NS; i++) begin : g_step
    logic          v_q;
    item_t         it_q;
    logic [TW-1:0] r_q, d_q;
    logic [QW-1:0] q_q;
    logic [TW:0]   rem, rem_sub;
    logic          ge;

    if (i == 1) begin : g_first
      assign rem = {1'b0, r_w[i-1]};
    end else begin : g_shift
      assign rem = {r_w[i-1], 1'b0};
    end
    assign ge      = (rem >= {1'b0, d_w[i-1]});
    assign rem_sub = ge ? (rem - {1'b0, d_w[i-1]}) : rem;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[i]) begin
        v_q <= v_w[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && v_w[i-1]) begin
        it_q <= it_w[i-1];
        d_q  <= d_w[i-1];
        r_q  <= rem_sub[TW-1:0];
        q_q  <= {q_w[i-1][QW-2:0], ge};
      end
    end

    assign v_w[i]  = v_q;
    assign it_w[i] = it_q;
    assign r_w[i]  = r_q;
    assign d_w[i]  = d_q;
    assign q_w[i]  = q_q;
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_w[NS-1];
  assign item_o      = it_w[NS-1];
  assign u_o         = q_w[NS-1];

endmodule

@@ rtl/ecint_curve.sv @@
module ecint_curve import ecint_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  item_t                       item_i,
  input  logic [FRAC_BITS:0]          u_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output item_t                       item_o,
  output logic signed [FRAC_BITS+3:0] f_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned UW = F + 1;
  localparam int unsigned AW = F + 4;
  localparam int unsigned PW = 2 * AW;
  localparam int unsigned LW = F + 6;
  localparam int unsigned MW = 2 * LW;
  localparam int unsigned FW = F + 4;
  localparam int unsigned XW = UW + 6;
  localparam int unsigned NS = 6;

  localparam longint unsigned C1_L  = ((64'd170158 << F) + 64'd50000) / 64'd100000;
  localparam longint unsigned C3_L  = ((64'd270158 << F) + 64'd50000) / 64'd100000;
  localparam longint unsigned C2_L  = ((64'd25949095 << F) + 64'd5000000) / 64'd10000000;
  localparam longint unsigned C2P_L = ((64'd35949095 << F) + 64'd5000000) / 64'd10000000;
  localparam longint unsigned K1_L  = ((64'd3 << F) + 64'd2) / 64'd4;
  localparam longint unsigned K2_L  = ((64'd15 << F) + 64'd8) / 64'd16;
  localparam longint unsigned K3_L  = ((64'd63 << F) + 64'd32) / 64'd64;

  localparam logic signed [AW-1:0] ONE_A = AW'(64'd1 << F);
  localparam logic signed [AW-1:0] C3_A  = AW'(C3_L);
  localparam logic signed [AW-1:0] C2P_A = AW'(C2P_L);
  localparam logic signed [LW-1:0] C1_N  = LW'(C1_L);
  localparam logic signed [LW-1:0] C2_N  = LW'(C2_L);
  localparam logic signed [LW-1:0] K1_N  = LW'(K1_L);
  localparam logic signed [LW-1:0] K2_N  = LW'(K2_L);
  localparam logic signed [LW-1:0] K3_N  = LW'(K3_L);
  localparam logic signed [FW-1:0] ONE_F = FW'(64'd1 << F);

  localparam logic [XW-1:0] X8  = XW'(64'd8 << F);
  localparam logic [XW-1:0] X16 = XW'(64'd16 << F);
  localparam logic [XW-1:0] X20 = XW'(64'd20 << F);
  localparam logic signed [XW:0] M12 = (XW+1)'(64'd12 << F);
  localparam logic signed [XW:0] M18 = (XW+1)'(64'd18 << F);
  localparam logic signed [XW:0] M21 = (XW+1)'(64'd21 << F);

  localparam logic signed [PW-1:0] HALF_P = PW'(64'd1 << (F - 1));
  localparam logic signed [PW-1:0] BRND_P = PW'(64'd1 << (F + 5));
  localparam logic signed [MW-1:0] HALF_M = MW'(64'd1 << (F - 1));

  typedef enum logic [3:0] {
    OP_LINEAR,
    OP_SQ,
    OP_ONE_MINUS_SQ,
    OP_BACK,
    OP_BACK_ONE,
    OP_HALF_BACK,
    OP_HALF_BACK_ONE,
    OP_BOUNCE,
    OP_ONE_MINUS_BOUNCE,
    OP_HALF_ONE_MINUS_BOUNCE,
    OP_HALF_BOUNCE_ONE
  } op_e;

  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;
  item_t         it_q [NS];
  logic [UW-1:0] u_q  [NS];
  op_e           op_q [NS];

  // Ready chain
  assign rdy[NS-1] = !v_q[NS-1] || !out_stall_i;
  for (genvar g = 0; g < NS - 1; g++) begin : g_rdy
    assign rdy[g] = !v_q[g] || rdy[g+1];
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Stage 0: pick operands per curve
  logic signed [AW-1:0] uz, wz, a0, b0, cm0;
  logic signed [LW-1:0] cadd0;
  logic signed [AW-1:0] bb0;
  logic                 lo;
  op_e                  op0;

  assign uz = $signed({3'b000, u_i});
  assign wz = ONE_A - uz;
  assign lo = (u_i[F:F-1] == 2'b00);

  always_comb begin
    a0    = uz;
    b0    = uz;
    cm0   = '0;
    cadd0 = '0;
    bb0   = uz;
    op0   = OP_LINEAR;
    unique case (item_i.sel)
      CURVE_QUAD_IN: begin
        op0 = OP_SQ;
      end
      CURVE_QUAD_OUT: begin
        a0  = wz;
        b0  = wz;
        op0 = OP_ONE_MINUS_SQ;
      end
      CURVE_QUAD_INOUT: begin
        if (lo) begin
          a0  = uz <<< 1;
          op0 = OP_SQ;
        end else begin
          a0  = wz <<< 1;
          b0  = wz;
          op0 = OP_ONE_MINUS_SQ;
        end
      end
      CURVE_BACK_IN: begin
        cm0   = C3_A;
        cadd0 = -C1_N;
        op0   = OP_BACK;
      end
      CURVE_BACK_OUT: begin
        a0    = uz - ONE_A;
        b0    = uz - ONE_A;
        cm0   = C3_A;
        cadd0 = C1_N;
        op0   = OP_BACK_ONE;
      end
      CURVE_BACK_INOUT: begin
        cm0 = C2P_A;
        if (lo) begin
          a0    = uz <<< 1;
          b0    = uz <<< 1;
          cadd0 = -C2_N;
          op0   = OP_HALF_BACK;
        end else begin
          a0    = (uz - ONE_A) <<< 1;
          b0    = (uz - ONE_A) <<< 1;
          cadd0 = C2_N;
          op0   = OP_HALF_BACK_ONE;
        end
      end
      CURVE_BOUNCE_OUT: begin
        op0 = OP_BOUNCE;
      end
      CURVE_BOUNCE_IN: begin
        bb0 = wz;
        op0 = OP_ONE_MINUS_BOUNCE;
      end
      CURVE_BOUNCE_INOUT: begin
        if (lo) begin
          bb0 = ONE_A - (uz <<< 1);
          op0 = OP_HALF_ONE_MINUS_BOUNCE;
        end else begin
          bb0 = (uz <<< 1) - ONE_A;
          op0 = OP_HALF_BOUNCE_ONE;
        end
      end
      default: begin
        op0 = OP_LINEAR;
      end
    endcase
  end

  logic signed [AW-1:0] a_q  [2];
  logic signed [AW-1:0] b_q  [2];
  logic signed [AW-1:0] cm_q [2];
  logic signed [LW-1:0] cadd_q [2];
  logic [UW-1:0]        bb1_q;
  logic signed [LW-1:0] k_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      it_q[0]   <= item_i;
      u_q[0]    <= u_i;
      op_q[0]   <= op0;
      a_q[0]    <= a0;
      b_q[0]    <= b0;
      cm_q[0]   <= cm0;
      cadd_q[0] <= cadd0;
      bb1_q     <= bb0[UW-1:0];
    end
  end

  // Stage 1: bounce segment and offset from the scaled base
  logic [XW-1:0]        x1;
  logic signed [XW:0]   m1;
  logic signed [XW:0]   dx1;
  logic signed [LW-1:0] k1;
  logic                 bounce1;

  assign x1 = (XW'(bb1_q) << 4) + (XW'(bb1_q) << 2) + (XW'(bb1_q) << 1);
  assign bounce1 = (op_q[0] == OP_BOUNCE) || (op_q[0] == OP_ONE_MINUS_BOUNCE) ||
                   (op_q[0] == OP_HALF_ONE_MINUS_BOUNCE) || (op_q[0] == OP_HALF_BOUNCE_ONE);

  always_comb begin
    priority if (x1 < X8) begin
      m1 = '0;
      k1 = '0;
    end else if (x1 < X16) begin
      m1 = M12;
      k1 = K1_N;
    end else if (x1 < X20) begin
      m1 = M18;
      k1 = K2_N;
    end else begin
      m1 = M21;
      k1 = K3_N;
    end
  end
  assign dx1 = $signed({1'b0, x1}) - m1;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      it_q[1]   <= it_q[0];
      u_q[1]    <= u_q[0];
      op_q[1]   <= op_q[0];
      a_q[1]    <= bounce1 ? AW'(dx1) : a_q[0];
      b_q[1]    <= bounce1 ? AW'(dx1) : b_q[0];
      cm_q[1]   <= cm_q[0];
      cadd_q[1] <= cadd_q[0];
      k_q       <= k1;
    end
  end

  // Stage 2: square and linear products
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [LW-1:0] cadd2_q, k2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      it_q[2] <= it_q[1];
      u_q[2]  <= u_q[1];
      op_q[2] <= op_q[1];
      p1_q    <= a_q[1] * b_q[1];
      p2_q    <= cm_q[1] * a_q[1];
      cadd2_q <= cadd_q[1];
      k2_q    <= k_q;
    end
  end

  // Stage 3: round products, add bounce offset or back constant
  logic signed [PW-1:0] sq_rnd, bq_rnd, ln_rnd;
  logic signed [LW-1:0] sq3, ln3;
  logic                 bounce3;
  logic signed [LW-1:0] sq3_q, ln3_q;

  assign bounce3 = (op_q[2] == OP_BOUNCE) || (op_q[2] == OP_ONE_MINUS_BOUNCE) ||
                   (op_q[2] == OP_HALF_ONE_MINUS_BOUNCE) || (op_q[2] == OP_HALF_BOUNCE_ONE);
  assign sq_rnd  = (p1_q + HALF_P) >>> F;
  assign bq_rnd  = (p1_q + BRND_P) >>> (F + 6);
  assign ln_rnd  = (p2_q + HALF_P) >>> F;
  assign sq3     = bounce3 ? (LW'(bq_rnd) + k2_q) : LW'(sq_rnd);
  assign ln3     = LW'(ln_rnd) + cadd2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      it_q[3] <= it_q[2];
      u_q[3]  <= u_q[2];
      op_q[3] <= op_q[2];
      sq3_q   <= sq3;
      ln3_q   <= ln3;
    end
  end

  // Stage 4: cubic product for the back curves
  logic signed [MW-1:0] p3_q;
  logic signed [LW-1:0] sq4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      it_q[4] <= it_q[3];
      u_q[4]  <= u_q[3];
      op_q[4] <= op_q[3];
      p3_q    <= sq3_q * ln3_q;
      sq4_q   <= sq3_q;
    end
  end

  // Stage 5: final weight
  logic signed [MW-1:0] r3_full;
  logic signed [FW-1:0] r3, sq5, f5, uf, h_in;

  assign r3_full = (p3_q + HALF_M) >>> F;
  assign r3      = FW'(r3_full);
  assign sq5     = FW'(sq4_q);
  assign uf      = $signed(FW'(u_q[4]));

  always_comb begin
    h_in = r3;
    f5   = uf;
    unique case (op_q[4])
      OP_SQ:                    f5 = sq5;
      OP_ONE_MINUS_SQ:          f5 = ONE_F - sq5;
      OP_BACK:                  f5 = r3;
      OP_BACK_ONE:              f5 = ONE_F + r3;
      OP_HALF_BACK:             f5 = (r3 + FW'(1)) >>> 1;
      OP_HALF_BACK_ONE:         f5 = ((r3 + FW'(1)) >>> 1) + ONE_F;
      OP_BOUNCE:                f5 = sq5;
      OP_ONE_MINUS_BOUNCE:      f5 = ONE_F - sq5;
      OP_HALF_ONE_MINUS_BOUNCE: begin
        h_in = ONE_F - sq5;
        f5   = (h_in + FW'(1)) >>> 1;
      end
      OP_HALF_BOUNCE_ONE: begin
        h_in = sq5 + ONE_F;
        f5   = (h_in + FW'(1)) >>> 1;
      end
      default:                  f5 = uf;
    endcase
  end

  logic signed [FW-1:0] f_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5] && v_q[4]) begin
      it_q[5] <= it_q[4];
      u_q[5]  <= u_q[4];
      op_q[5] <= op_q[4];
      f_q     <= f5;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign item_o      = it_q[NS-1];
  assign f_o         = f_q;

endmodule

@@ rtl/ecint_blend.sv @@
module ecint_blend import ecint_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  item_t                       item_i,
  input  logic signed [FRAC_BITS+3:0] f_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ValueW-1:0]           value_o,
  output logic                        sat_o,
  output logic                        bad_o
);

  localparam int unsigned FW = FRAC_BITS + 4;
  localparam int unsigned DW = ValueW + 1;
  localparam int unsigned PW = DW + FW;
  localparam int unsigned RW = PW - FRAC_BITS + 1;
  localparam int unsigned NS = 3;

  localparam logic signed [PW-1:0] HALF_P = PW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [RW-1:0] MAXV   = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] MINV   = RW'(-64'sd2147483648);

  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;

  // Ready chain
  assign rdy[NS-1] = !v_q[NS-1] || !out_stall_i;
  for (genvar g = 0; g < NS - 1; g++) begin : g_rdy
    assign rdy[g] = !v_q[g] || rdy[g+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Stage 0: span between end and start
  logic signed [DW-1:0]     mv_q;
  logic signed [FW-1:0]     f0_q;
  logic [ValueW-1:0]        st_q [NS-1];
  logic                     bd_q [NS-1];

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      mv_q    <= $signed({item_i.end_val[ValueW-1], item_i.end_val}) -
                 $signed({item_i.start_val[ValueW-1], item_i.start_val});
      f0_q    <= f_i;
      st_q[0] <= item_i.start_val;
      bd_q[0] <= item_i.bad;
    end
  end

  // Stage 1: scale the span by the weight
  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      p_q     <= mv_q * f0_q;
      st_q[1] <= st_q[0];
      bd_q[1] <= bd_q[0];
    end
  end

  // Stage 2: round, add start, clip to 32 bits; a bad duration passes start through
  logic signed [PW-1:0] sh;
  logic signed [RW-1:0] sum;
  logic                 hi, lw;
  logic [ValueW-1:0]    res_q;
  logic                 sat_q, bad_q;

  assign sh  = (p_q + HALF_P) >>> FRAC_BITS;
  assign sum = RW'(sh) + RW'($signed(st_q[1]));
  assign hi  = (sum > MAXV);
  assign lw  = (sum < MINV);

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      bad_q <= bd_q[1];
      priority if (bd_q[1]) begin
        res_q <= st_q[1];
        sat_q <= 1'b0;
      end else if (hi) begin
        res_q <= MAXV[ValueW-1:0];
        sat_q <= 1'b1;
      end else if (lw) begin
        res_q <= MINV[ValueW-1:0];
        sat_q <= 1'b1;
      end else begin
        res_q <= sum[ValueW-1:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign value_o     = res_q;
  assign sat_o       = sat_q;
  assign bad_o       = bad_q;

  // Checks on the output stage and the input stall
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && sat_q |-> (res_q == MAXV[ValueW-1:0]) || (res_q == MINV[ValueW-1:0]))
    else $error("clipped result is not a range limit");

  a_bad_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && bad_q |-> !sat_q)
    else $error("zero duration result flagged as clipped");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && out_stall_i |=> v_q[NS-1] && $stable(res_q) && $stable(sat_q))
    else $error("stalled result changed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v_q[0] && v_q[1] && v_q[2])
    else $error("input stalled with an empty stage");

endmodule

@@ rtl/easing_curve_interpolator.sv @@
// Channel | Handshake                | Payload
// in      | in_valid_i / in_stall_o  | action, start/end value, elapsed/duration ticks
// out     | out_valid_o / out_stall_i| eased_value, saturated, bad_duration
//
// One request per cycle sustained while the output is not stalled; the restoring
// divider computes one quotient bit per stage.
// Reset (async, active low) clears all stage valid bits; payload is not reset.
// A stall holds the output; upstream stages keep filling empty slots, so the
// input stalls only when every stage holds a request.
module easing_curve_interpolator import ecint_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        action_i,
  input  logic [ValueW-1:0] start_value_i,
  input  logic [ValueW-1:0] end_value_i,
  input  logic [TicksW-1:0] elapsed_ticks_i,
  input  logic [TicksW-1:0] duration_ticks_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] eased_value_o,
  output logic              saturated_o,
  output logic              bad_duration_o
);

  item_t                       in_item, div_item, crv_item;
  logic                        div_valid, div_stall, crv_valid, crv_stall;
  logic [FRAC_BITS:0]          u;
  logic signed [FRAC_BITS+3:0] f;

  assign in_item.sel       = action_i;
  assign in_item.start_val = start_value_i;
  assign in_item.end_val   = end_value_i;
  assign in_item.bad       = 1'b0;

  ecint_div #(
    .FRAC_BITS (FRAC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .elapsed_i   (elapsed_ticks_i),
    .duration_i  (duration_ticks_i),
    .out_valid_o (div_valid),
    .out_stall_i (div_stall),
    .item_o      (div_item),
    .u_o         (u)
  );

  ecint_curve #(
    .FRAC_BITS (FRAC_BITS)
  ) u_curve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_stall_o  (div_stall),
    .item_i      (div_item),
    .u_i         (u),
    .out_valid_o (crv_valid),
    .out_stall_i (crv_stall),
    .item_o      (crv_item),
    .f_o         (f)
  );

  ecint_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (crv_valid),
    .in_stall_o  (crv_stall),
    .item_i      (crv_item),
    .f_i         (f),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (eased_value_o),
    .sat_o       (saturated_o),
    .bad_o       (bad_duration_o)
  );

endmodule
